/* src/npci_pkg.sv */
package npci_pkg;

  localparam int ChanW = 8;
  localparam int IdxW = 8;
  localparam int DistW = 18;
  localparam int RomDepth = 256;
  localparam logic [DistW-1:0] SearchLimit = 18'd10000;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic [DistW-1:0] best_dist;
    logic [IdxW-1:0]  best_idx;
  } best_t;

  function automatic color_t rgb(input int r, input int g, input int b);
    color_t c;
    c.red = ChanW'(r);
    c.green = ChanW'(g);
    c.blue = ChanW'(b);
    return c;
  endfunction

  function automatic color_t palette(input logic [IdxW-1:0] i);
    color_t c;
    unique case (i)
      8'd0: c = rgb(0,0,0); 8'd1: c = rgb(255,0,0); 8'd2: c = rgb(255,255,0);
      8'd3: c = rgb(0,255,0); 8'd4: c = rgb(0,255,255); 8'd5: c = rgb(0,0,255);
      8'd6: c = rgb(255,0,255); 8'd7: c = rgb(255,255,255); 8'd8: c = rgb(128,128,128);
      8'd9: c = rgb(192,192,192); 8'd10: c = rgb(255,0,0); 8'd11: c = rgb(255,127,127);
      8'd12: c = rgb(165,0,0); 8'd13: c = rgb(165,82,82); 8'd14: c = rgb(127,0,0);
      8'd15: c = rgb(127,63,63); 8'd16: c = rgb(76,0,0); 8'd17: c = rgb(76,38,38);
      8'd18: c = rgb(38,0,0); 8'd19: c = rgb(38,19,19); 8'd20: c = rgb(255,63,0);
      8'd21: c = rgb(255,159,127); 8'd22: c = rgb(165,41,0); 8'd23: c = rgb(165,103,82);
      8'd24: c = rgb(127,31,0); 8'd25: c = rgb(127,79,63); 8'd26: c = rgb(76,19,0);
      8'd27: c = rgb(76,47,38); 8'd28: c = rgb(38,9,0); 8'd29: c = rgb(38,28,19);
      8'd30: c = rgb(255,127,0); 8'd31: c = rgb(255,191,127); 8'd32: c = rgb(165,82,0);
      8'd33: c = rgb(165,124,82); 8'd34: c = rgb(127,63,0); 8'd35: c = rgb(127,95,63);
      8'd36: c = rgb(76,38,0); 8'd37: c = rgb(76,57,38); 8'd38: c = rgb(38,19,0);
      8'd39: c = rgb(38,28,19); 8'd40: c = rgb(255,191,0); 8'd41: c = rgb(255,223,127);
      8'd42: c = rgb(165,124,0); 8'd43: c = rgb(165,145,82); 8'd44: c = rgb(127,95,0);
      8'd45: c = rgb(127,111,63); 8'd46: c = rgb(76,57,0); 8'd47: c = rgb(76,66,38);
      8'd48: c = rgb(38,28,0); 8'd49: c = rgb(38,33,19); 8'd50: c = rgb(255,255,0);
      8'd51: c = rgb(255,255,127); 8'd52: c = rgb(165,165,0); 8'd53: c = rgb(165,165,82);
      8'd54: c = rgb(127,127,0); 8'd55: c = rgb(127,127,63); 8'd56: c = rgb(76,76,0);
      8'd57: c = rgb(76,76,38); 8'd58: c = rgb(38,38,0); 8'd59: c = rgb(38,38,19);
      8'd60: c = rgb(191,255,0); 8'd61: c = rgb(223,255,127); 8'd62: c = rgb(124,165,0);
      8'd63: c = rgb(145,165,82); 8'd64: c = rgb(95,127,0); 8'd65: c = rgb(111,127,63);
      8'd66: c = rgb(57,76,0); 8'd67: c = rgb(66,76,38); 8'd68: c = rgb(28,38,0);
      8'd69: c = rgb(33,38,19); 8'd70: c = rgb(127,255,0); 8'd71: c = rgb(191,255,127);
      8'd72: c = rgb(82,165,0); 8'd73: c = rgb(124,165,82); 8'd74: c = rgb(63,127,0);
      8'd75: c = rgb(95,127,63); 8'd76: c = rgb(38,76,0); 8'd77: c = rgb(57,76,38);
      8'd78: c = rgb(19,38,0); 8'd79: c = rgb(28,38,19); 8'd80: c = rgb(63,255,0);
      8'd81: c = rgb(159,255,127); 8'd82: c = rgb(41,165,0); 8'd83: c = rgb(103,165,82);
      8'd84: c = rgb(31,127,0); 8'd85: c = rgb(79,127,63); 8'd86: c = rgb(19,76,0);
      8'd87: c = rgb(47,76,38); 8'd88: c = rgb(9,38,0); 8'd89: c = rgb(23,38,19);
      8'd90: c = rgb(0,255,0); 8'd91: c = rgb(125,255,127); 8'd92: c = rgb(0,165,0);
      8'd93: c = rgb(82,165,82); 8'd94: c = rgb(0,127,0); 8'd95: c = rgb(63,127,63);
      8'd96: c = rgb(0,76,0); 8'd97: c = rgb(38,76,38); 8'd98: c = rgb(0,38,0);
      8'd99: c = rgb(19,38,19); 8'd100: c = rgb(0,255,63); 8'd101: c = rgb(127,255,159);
      8'd102: c = rgb(0,165,41); 8'd103: c = rgb(82,165,103); 8'd104: c = rgb(0,127,31);
      8'd105: c = rgb(63,127,79); 8'd106: c = rgb(0,76,19); 8'd107: c = rgb(38,76,47);
      8'd108: c = rgb(0,38,9); 8'd109: c = rgb(19,88,23); 8'd110: c = rgb(0,255,127);
      8'd111: c = rgb(127,255,191); 8'd112: c = rgb(0,165,82); 8'd113: c = rgb(82,165,124);
      8'd114: c = rgb(0,127,63); 8'd115: c = rgb(63,127,95); 8'd116: c = rgb(0,76,38);
      8'd117: c = rgb(38,76,57); 8'd118: c = rgb(0,38,19); 8'd119: c = rgb(19,88,28);
      8'd120: c = rgb(0,255,191); 8'd121: c = rgb(127,255,223); 8'd122: c = rgb(0,165,124);
      8'd123: c = rgb(82,165,145); 8'd124: c = rgb(0,127,95); 8'd125: c = rgb(63,127,111);
      8'd126: c = rgb(0,76,57); 8'd127: c = rgb(38,76,66); 8'd128: c = rgb(0,38,28);
      8'd129: c = rgb(19,88,88); 8'd130: c = rgb(0,255,255); 8'd131: c = rgb(127,255,255);
      8'd132: c = rgb(0,165,165); 8'd133: c = rgb(82,165,165); 8'd134: c = rgb(0,127,127);
      8'd135: c = rgb(63,127,127); 8'd136: c = rgb(0,76,76); 8'd137: c = rgb(38,76,76);
      8'd138: c = rgb(0,38,38); 8'd139: c = rgb(19,88,88); 8'd140: c = rgb(0,191,255);
      8'd141: c = rgb(127,223,255); 8'd142: c = rgb(0,124,165); 8'd143: c = rgb(82,145,165);
      8'd144: c = rgb(0,95,127); 8'd145: c = rgb(63,111,217); 8'd146: c = rgb(0,57,76);
      8'd147: c = rgb(38,66,126); 8'd148: c = rgb(0,28,38); 8'd149: c = rgb(19,88,88);
      8'd150: c = rgb(0,127,255); 8'd151: c = rgb(127,191,255); 8'd152: c = rgb(0,82,165);
      8'd153: c = rgb(82,124,165); 8'd154: c = rgb(0,63,127); 8'd155: c = rgb(63,95,127);
      8'd156: c = rgb(0,38,76); 8'd157: c = rgb(38,57,126); 8'd158: c = rgb(0,19,38);
      8'd159: c = rgb(19,28,88); 8'd160: c = rgb(0,63,255); 8'd161: c = rgb(127,159,255);
      8'd162: c = rgb(0,41,165); 8'd163: c = rgb(82,103,165); 8'd164: c = rgb(0,31,127);
      8'd165: c = rgb(63,79,127); 8'd166: c = rgb(0,19,76); 8'd167: c = rgb(38,47,126);
      8'd168: c = rgb(0,9,38); 8'd169: c = rgb(19,23,88); 8'd170: c = rgb(0,0,255);
      8'd171: c = rgb(127,127,255); 8'd172: c = rgb(0,0,165); 8'd173: c = rgb(82,82,165);
      8'd174: c = rgb(0,0,127); 8'd175: c = rgb(63,63,127); 8'd176: c = rgb(0,0,76);
      8'd177: c = rgb(38,38,126); 8'd178: c = rgb(0,0,38); 8'd179: c = rgb(19,19,88);
      8'd180: c = rgb(63,0,255); 8'd181: c = rgb(159,127,255); 8'd182: c = rgb(41,0,165);
      8'd183: c = rgb(103,82,165); 8'd184: c = rgb(31,0,127); 8'd185: c = rgb(79,63,127);
      8'd186: c = rgb(19,0,76); 8'd187: c = rgb(47,38,126); 8'd188: c = rgb(9,0,38);
      8'd189: c = rgb(23,19,88); 8'd190: c = rgb(127,0,255); 8'd191: c = rgb(191,127,255);
      8'd192: c = rgb(165,0,82); 8'd193: c = rgb(124,82,165); 8'd194: c = rgb(63,0,127);
      8'd195: c = rgb(95,63,127); 8'd196: c = rgb(38,0,76); 8'd197: c = rgb(57,38,126);
      8'd198: c = rgb(19,0,38); 8'd199: c = rgb(28,19,88); 8'd200: c = rgb(191,0,255);
      8'd201: c = rgb(223,127,255); 8'd202: c = rgb(124,0,165); 8'd203: c = rgb(142,82,165);
      8'd204: c = rgb(95,0,127); 8'd205: c = rgb(111,63,127); 8'd206: c = rgb(57,0,76);
      8'd207: c = rgb(66,38,76); 8'd208: c = rgb(28,0,38); 8'd209: c = rgb(88,19,88);
      8'd210: c = rgb(255,0,255); 8'd211: c = rgb(255,127,255); 8'd212: c = rgb(165,0,165);
      8'd213: c = rgb(165,82,165); 8'd214: c = rgb(127,0,127); 8'd215: c = rgb(127,63,127);
      8'd216: c = rgb(76,0,76); 8'd217: c = rgb(76,38,76); 8'd218: c = rgb(38,0,38);
      8'd219: c = rgb(88,19,88); 8'd220: c = rgb(255,0,191); 8'd221: c = rgb(255,127,223);
      8'd222: c = rgb(165,0,124); 8'd223: c = rgb(165,82,145); 8'd224: c = rgb(127,0,95);
      8'd225: c = rgb(127,63,111); 8'd226: c = rgb(76,0,57); 8'd227: c = rgb(76,38,66);
      8'd228: c = rgb(38,0,28); 8'd229: c = rgb(88,19,88); 8'd230: c = rgb(255,0,127);
      8'd231: c = rgb(255,127,191); 8'd232: c = rgb(165,0,82); 8'd233: c = rgb(165,82,124);
      8'd234: c = rgb(127,0,63); 8'd235: c = rgb(127,63,95); 8'd236: c = rgb(76,0,38);
      8'd237: c = rgb(76,38,57); 8'd238: c = rgb(38,0,19); 8'd239: c = rgb(88,19,28);
      8'd240: c = rgb(255,0,63); 8'd241: c = rgb(255,127,159); 8'd242: c = rgb(165,0,41);
      8'd243: c = rgb(165,82,103); 8'd244: c = rgb(127,0,31); 8'd245: c = rgb(127,63,79);
      8'd246: c = rgb(76,0,19); 8'd247: c = rgb(76,38,47); 8'd248: c = rgb(38,0,9);
      8'd249: c = rgb(88,19,23); 8'd250: c = rgb(0,0,0); 8'd251: c = rgb(101,101,101);
      8'd252: c = rgb(102,102,102); 8'd253: c = rgb(153,153,153); 8'd254: c = rgb(204,204,204);
      8'd255: c = rgb(255,255,255);
      default: c = rgb(0,0,0);
    endcase
    return c;
  endfunction

endpackage

/* src/npci_if.sv */
interface npci_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/npci_cell.sv */
module npci_cell
  import npci_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                run,
  input  logic                cell_valid_in,
  input  logic [IdxW-1:0]     cell_idx,
  input  color_t              color_in,
  input  best_t               best_in,
  output logic                cell_valid_out,
  output color_t              color_out,
  output best_t               best_out
);

  color_t             ent;
  logic [ChanW:0]     dr, dg, db;
  logic [2*ChanW-1:0] sr, sg, sb;
  logic [DistW-1:0]   sq_dist;

  // Signed 9-bit differences; squares of magnitudes up to 255 fit in 16 bits.
  always_comb begin
    ent = palette(cell_idx);
    dr = {1'b0, color_in.red} - {1'b0, ent.red};
    dg = {1'b0, color_in.green} - {1'b0, ent.green};
    db = {1'b0, color_in.blue} - {1'b0, ent.blue};
    if (dr[ChanW]) dr = -dr;
    if (dg[ChanW]) dg = -dg;
    if (db[ChanW]) db = -db;
    sr = dr[ChanW-1:0] * dr[ChanW-1:0];
    sg = dg[ChanW-1:0] * dg[ChanW-1:0];
    sb = db[ChanW-1:0] * db[ChanW-1:0];
    sq_dist = {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid_out <= 1'b0;
    end else if (run) begin
      cell_valid_out <= cell_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      color_out <= color_in;
      if (sq_dist < best_in.best_dist) begin
        best_out.best_dist <= sq_dist;
        best_out.best_idx <= cell_idx;
      end else begin
        best_out <= best_in;
      end
    end
  end

endmodule

/* src/nearest_palette_color_index.sv */
// Pipelined search: one registered cell per palette entry.
// Each input word passes through the register of every cell in turn before it leaves as the output word.
// Throughput is one word per cycle; the whole chain stalls while the output word waits.
// Synchronous active-high rst clears all valid flags; payload registers are not reset.
module nearest_palette_color_index
  import npci_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
)(
  input  logic      clk,
  input  logic      rst,
  npci_if.sink      in_ch,
  npci_if.source    out_ch
);

  localparam int N = (PALETTE_ENTRIES > RomDepth) ? RomDepth : PALETTE_ENTRIES;

  logic   run;
  logic   v [N+1];
  color_t c [N+1];
  best_t  b [N+1];

  assign run = ~v[N] | out_ch.ready;
  assign in_ch.ready = run;

  assign v[0] = in_ch.valid;
  assign c[0] = color_t'(in_ch.data);
  assign b[0].best_dist = SearchLimit;
  assign b[0].best_idx = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    npci_cell u_cell (
      .clk(clk), .rst(rst), .run(run),
      .cell_valid_in(v[i]), .cell_idx(IdxW'(i)),
      .color_in(c[i]), .best_in(b[i]),
      .cell_valid_out(v[i+1]), .color_out(c[i+1]), .best_out(b[i+1])
    );
  end

  assign out_ch.valid = v[N];
  assign out_ch.data = b[N].best_idx;

endmodule

/* tb/nearest_palette_checker.sv */
module nearest_palette_checker
  import npci_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [3*ChanW-1:0] in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [IdxW-1:0]  out_data,
  output int               fail_count,
  output int               pending
);

  // Table kept here on its own so the check does not lean on the block's ROM.
  logic [23:0] color_table [RomDepth];
  logic [IdxW-1:0] expected_index [$];

  initial begin
    int k;
    int vals [768] = '{
      0,0,0, 255,0,0, 255,255,0, 0,255,0, 0,255,255, 0,0,255, 255,0,255, 255,255,255,
      128,128,128, 192,192,192, 255,0,0, 255,127,127, 165,0,0, 165,82,82, 127,0,0,
      127,63,63, 76,0,0, 76,38,38, 38,0,0, 38,19,19, 255,63,0, 255,159,127, 165,41,0,
      165,103,82, 127,31,0, 127,79,63, 76,19,0, 76,47,38, 38,9,0, 38,28,19, 255,127,0,
      255,191,127, 165,82,0, 165,124,82, 127,63,0, 127,95,63, 76,38,0, 76,57,38,
      38,19,0, 38,28,19, 255,191,0, 255,223,127, 165,124,0, 165,145,82, 127,95,0,
      127,111,63, 76,57,0, 76,66,38, 38,28,0, 38,33,19, 255,255,0, 255,255,127,
      165,165,0, 165,165,82, 127,127,0, 127,127,63, 76,76,0, 76,76,38, 38,38,0,
      38,38,19, 191,255,0, 223,255,127, 124,165,0, 145,165,82, 95,127,0, 111,127,63,
      57,76,0, 66,76,38, 28,38,0, 33,38,19, 127,255,0, 191,255,127, 82,165,0,
      124,165,82, 63,127,0, 95,127,63, 38,76,0, 57,76,38, 19,38,0, 28,38,19, 63,255,0,
      159,255,127, 41,165,0, 103,165,82, 31,127,0, 79,127,63, 19,76,0, 47,76,38,
      9,38,0, 23,38,19, 0,255,0, 125,255,127, 0,165,0, 82,165,82, 0,127,0, 63,127,63,
      0,76,0, 38,76,38, 0,38,0, 19,38,19, 0,255,63, 127,255,159, 0,165,41, 82,165,103,
      0,127,31, 63,127,79, 0,76,19, 38,76,47, 0,38,9, 19,88,23, 0,255,127, 127,255,191,
      0,165,82, 82,165,124, 0,127,63, 63,127,95, 0,76,38, 38,76,57, 0,38,19, 19,88,28,
      0,255,191, 127,255,223, 0,165,124, 82,165,145, 0,127,95, 63,127,111, 0,76,57,
      38,76,66, 0,38,28, 19,88,88, 0,255,255, 127,255,255, 0,165,165, 82,165,165,
      0,127,127, 63,127,127, 0,76,76, 38,76,76, 0,38,38, 19,88,88, 0,191,255,
      127,223,255, 0,124,165, 82,145,165, 0,95,127, 63,111,217, 0,57,76, 38,66,126,
      0,28,38, 19,88,88, 0,127,255, 127,191,255, 0,82,165, 82,124,165, 0,63,127,
      63,95,127, 0,38,76, 38,57,126, 0,19,38, 19,28,88, 0,63,255, 127,159,255,
      0,41,165, 82,103,165, 0,31,127, 63,79,127, 0,19,76, 38,47,126, 0,9,38, 19,23,88,
      0,0,255, 127,127,255, 0,0,165, 82,82,165, 0,0,127, 63,63,127, 0,0,76, 38,38,126,
      0,0,38, 19,19,88, 63,0,255, 159,127,255, 41,0,165, 103,82,165, 31,0,127,
      79,63,127, 19,0,76, 47,38,126, 9,0,38, 23,19,88, 127,0,255, 191,127,255,
      165,0,82, 124,82,165, 63,0,127, 95,63,127, 38,0,76, 57,38,126, 19,0,38, 28,19,88,
      191,0,255, 223,127,255, 124,0,165, 142,82,165, 95,0,127, 111,63,127, 57,0,76,
      66,38,76, 28,0,38, 88,19,88, 255,0,255, 255,127,255, 165,0,165, 165,82,165,
      127,0,127, 127,63,127, 76,0,76, 76,38,76, 38,0,38, 88,19,88, 255,0,191,
      255,127,223, 165,0,124, 165,82,145, 127,0,95, 127,63,111, 76,0,57, 76,38,66,
      38,0,28, 88,19,88, 255,0,127, 255,127,191, 165,0,82, 165,82,124, 127,0,63,
      127,63,95, 76,0,38, 76,38,57, 38,0,19, 88,19,28, 255,0,63, 255,127,159,
      165,0,41, 165,82,103, 127,0,31, 127,63,79, 76,0,19, 76,38,47, 38,0,9, 88,19,23,
      0,0,0, 101,101,101, 102,102,102, 153,153,153, 204,204,204, 255,255,255};
    for (k = 0; k < RomDepth; k++) begin
      color_table[k] = {vals[3*k][7:0], vals[3*k+1][7:0], vals[3*k+2][7:0]};
    end
  end

  function automatic logic [IdxW-1:0] nearest_index(input logic [3*ChanW-1:0] c);
    int best_dist;
    int best;
    int dr, dg, db, d, k;
    best_dist = 10000;
    best = 0;
    for (k = 0; k < RomDepth; k++) begin
      dr = int'(c[23:16]) - int'(color_table[k][23:16]);
      dg = int'(c[15:8]) - int'(color_table[k][15:8]);
      db = int'(c[7:0]) - int'(color_table[k][7:0]);
      d = dr * dr + dg * dg + db * db;
      if (d < best_dist) begin
        best_dist = d;
        best = k;
      end
    end
    return IdxW'(best);
  endfunction

  assign pending = expected_index.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [IdxW-1:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_index.push_back(nearest_index(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_index.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected output word color_index=%0d", out_data);
          end
        end else begin
          want = expected_index.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("color_index mismatch: expected %0d, got %0d", want, out_data);
            end
          end
        end
      end
    end
  end

endmodule

/* tb/tb_nearest_palette_color_index.sv */
module tb_nearest_palette_color_index;
  import npci_pkg::*;

  localparam int Latency = 256;
  localparam int RandomColors = 1130;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  logic calm;
  logic hold_off;

  npci_if #(.W(3 * ChanW)) in_ch ();
  npci_if #(.W(IdxW)) out_ch ();

  nearest_palette_color_index dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  nearest_palette_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_data(in_ch.data),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(out_ch.data),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off, none once calm is set.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < 600; n++) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {r, g, b};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int k, wait_cycles;
    logic [23:0] c;
    calm = 1'b0;
    hold_off = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes, the odd table entries, exact ties and a color far from all.
    send_color(8'd0, 8'd0, 8'd0);
    send_color(8'd255, 8'd255, 8'd255);
    send_color(8'd255, 8'd0, 8'd0);
    send_color(8'd0, 8'd255, 8'd0);
    send_color(8'd0, 8'd0, 8'd255);
    send_color(8'd19, 8'd88, 8'd23);
    send_color(8'd63, 8'd111, 8'd217);
    send_color(8'd101, 8'd101, 8'd101);
    send_color(8'd19, 8'd88, 8'd88);
    send_color(8'd88, 8'd19, 8'd88);
    send_color(8'd165, 8'd0, 8'd82);
    send_color(8'd170, 8'd85, 8'd170);
    send_color(8'd128, 8'd128, 8'd128);
    send_color(8'd0, 8'd255, 8'd127);
    send_color(8'd170, 8'd0, 8'd85);
    send_color(8'd85, 8'd170, 8'd255);
    send_color(8'd1, 8'd2, 8'd4);
    send_color(8'd254, 8'd253, 8'd251);
    send_color(8'd127, 8'd128, 8'd126);
    send_color(8'd200, 8'd60, 8'd120);

    for (k = 0; k < RandomColors; k++) begin
      if (k == 300) hold_off = 1'b1;
      if (k == RandomColors - 150) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        // Near a table entry, to stress ties and duplicate entries.
        c = checker_i.color_table[$urandom_range(0, RomDepth - 1)];
        c[23:16] = c[23:16] + 8'($urandom_range(0, 6)) - 8'd3;
        c[15:8] = c[15:8] + 8'($urandom_range(0, 6)) - 8'd3;
        c[7:0] = c[7:0] + 8'($urandom_range(0, 6)) - 8'd3;
      end else begin
        c = 24'($urandom());
      end
      send_color(c[23:16], c[15:8], c[7:0]);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (Latency + 20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/npci_pkg.sv
src/npci_if.sv
src/npci_cell.sv
src/nearest_palette_color_index.sv
tb/nearest_palette_checker.sv
tb/tb_nearest_palette_color_index.sv
